// ===== rtl/sps_pkg.sv =====
`default_nettype none

package sps_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam int unsigned CYC_W   = 17;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned ANGLE_W = 16;

  // floor(a*64/45) == (a * ceil(2^28/45)) >> 22, exact for a below 2^16
  localparam logic [22:0] CYC_RECIP = 23'd5965233;
  localparam int unsigned CYC_SHIFT = 22;

  typedef struct packed {
    logic [1:0]         kind;
    logic               half_step;
    logic               direction;
    logic [TICKS_W-1:0] phase_ticks;
    logic [CYC_W-1:0]   cycles;
  } sps_item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       busy;
    logic       done;
    logic       ignored;
  } sps_result_t;

  function automatic logic [3:0] pattern_at(input logic half, input logic ccw,
                                            input logic [2:0] idx);
    logic [2:0] k;
    logic [3:0] pat;
    k = idx;
    if (ccw) begin
      k = half ? (3'd7 - idx) : {1'b0, 2'd3 - idx[1:0]};
    end
    if (half) begin
      case (k)
        3'd0:    pat = 4'h1;
        3'd1:    pat = 4'h3;
        3'd2:    pat = 4'h2;
        3'd3:    pat = 4'h6;
        3'd4:    pat = 4'h4;
        3'd5:    pat = 4'hC;
        3'd6:    pat = 4'h8;
        default: pat = 4'h9;
      endcase
    end else begin
      case (k[1:0])
        2'd0:    pat = 4'h1;
        2'd1:    pat = 4'h2;
        2'd2:    pat = 4'h4;
        default: pat = 4'h8;
      endcase
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sps_in_stage.sv =====
`default_nettype none

module sps_in_stage
  import sps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               advance,
  input  wire logic [1:0]         kind,
  input  wire logic               half_step,
  input  wire logic               direction,
  input  wire logic [TICKS_W-1:0] phase_ticks,
  input  wire logic [ANGLE_W-1:0] angle_deg,
  output      logic               item_valid,
  output      sps_item_t          item
);

  logic                         valid_r;
  logic                         valid_nxt;
  sps_item_t                    item_r;
  sps_item_t                    item_nxt;
  logic [ANGLE_W+23-1:0]        prod;

  // cycle count is worked out before the register so the step logic stays short
  assign prod = {{23{1'b0}}, angle_deg} * {{ANGLE_W{1'b0}}, CYC_RECIP};

  always_comb begin
    item_nxt.kind        = kind;
    item_nxt.half_step   = half_step;
    item_nxt.direction   = direction;
    item_nxt.phase_ticks = phase_ticks;
    item_nxt.cycles      = prod[CYC_SHIFT +: CYC_W];
    valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/sps_core.sv =====
`default_nettype none

module sps_core
  import sps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire sps_item_t   item,
  output      sps_result_t result
);

  logic [3:0]         coil_r,   coil_nxt;
  logic [2:0]         idx_r,    idx_nxt;
  logic [CYC_W-1:0]   cyc_r,    cyc_nxt;
  logic [TICKS_W-1:0] hold_r,   hold_nxt;
  logic [TICKS_W-1:0] hlen_r,   hlen_nxt;
  logic               half_r,   half_nxt;
  logic               ccw_r,    ccw_nxt;
  logic               run_r,    run_nxt;

  logic               done;
  logic               ignored;
  logic [TICKS_W-1:0] hold_dec;
  logic [TICKS_W-1:0] ticks_eff;
  logic [3:0]         next_idx;
  logic [CYC_W-1:0]   cyc_dec;
  logic               wrap;

  always_comb begin
    coil_nxt = coil_r;
    idx_nxt  = idx_r;
    cyc_nxt  = cyc_r;
    hold_nxt = hold_r;
    hlen_nxt = hlen_r;
    half_nxt = half_r;
    ccw_nxt  = ccw_r;
    run_nxt  = run_r;
    done     = 1'b0;
    ignored  = 1'b0;

    ticks_eff = (item.phase_ticks == '0) ? TICKS_W'(1) : item.phase_ticks;
    hold_dec  = (hold_r != '0) ? hold_r - TICKS_W'(1) : hold_r;
    next_idx  = {1'b0, idx_r} + 4'd1;
    wrap      = half_r ? (next_idx >= 4'd8) : (next_idx >= 4'd4);
    cyc_dec   = cyc_r;
    if (wrap && cyc_r != '0) begin
      cyc_dec = cyc_r - CYC_W'(1);
    end

    unique case (item.kind)
      KIND_START: begin
        if (run_r) begin
          ignored = 1'b1;
        end else if (item.cycles == '0) begin
          done = 1'b1;
        end else begin
          half_nxt = item.half_step;
          ccw_nxt  = item.direction;
          hlen_nxt = ticks_eff;
          cyc_nxt  = item.cycles;
          idx_nxt  = 3'd0;
          hold_nxt = ticks_eff;
          coil_nxt = pattern_at(item.half_step, item.direction, 3'd0);
          run_nxt  = 1'b1;
        end
      end
      KIND_STOP: begin
        coil_nxt = 4'h0;
        idx_nxt  = 3'd0;
        cyc_nxt  = '0;
        hold_nxt = '0;
        run_nxt  = 1'b0;
      end
      KIND_TICK: begin
        if (run_r) begin
          hold_nxt = hold_dec;
          if (hold_dec == '0) begin
            cyc_nxt = cyc_dec;
            if (wrap && cyc_dec == '0) begin
              run_nxt = 1'b0;
              done    = 1'b1;
              idx_nxt = 3'd0;
            end else begin
              idx_nxt  = wrap ? 3'd0 : next_idx[2:0];
              coil_nxt = pattern_at(half_r, ccw_r, wrap ? 3'd0 : next_idx[2:0]);
              hold_nxt = hlen_r;
            end
          end
        end
      end
      default: begin
        // unused kind leaves everything as it is
      end
    endcase

    result.coils   = coil_nxt;
    result.busy    = run_nxt;
    result.done    = done;
    result.ignored = ignored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_r <= 4'h0;
      idx_r  <= 3'd0;
      cyc_r  <= '0;
      hold_r <= '0;
      hlen_r <= TICKS_W'(1);
      half_r <= 1'b0;
      ccw_r  <= 1'b0;
      run_r  <= 1'b0;
    end else if (advance) begin
      coil_r <= coil_nxt;
      idx_r  <= idx_nxt;
      cyc_r  <= cyc_nxt;
      hold_r <= hold_nxt;
      hlen_r <= hlen_nxt;
      half_r <= half_nxt;
      ccw_r  <= ccw_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stepper_phase_sequencer.sv =====
// Unipolar stepper phase sequencer: drives blue, pink, yellow and orange coils.
// Input channel (in_*): one request per item; kind selects a millisecond tick,
// a start (mode, direction, hold ticks, angle) or a stop.
// Output channel (out_*): exactly one result per request, in order, with the
// coil pattern after that request and busy, done and start-ignored flags.
// Both channels use valid/stall; a request or result moves on an edge where
// valid is high and stall is low.
// A request accepted at an edge is held in the input register, then passes
// through the state update into the result register.
// Throughput: one request per cycle while the receiver does not stall, set by
// the state update between those registers; the angle-to-cycle multiply sits
// before the input register.
// When the receiver stalls the result holds, the input register fills and
// in_stall rises only while both registers are occupied.
// Reset (rst_n low, synchronous): coils off, idle, hold length one, both
// registers empty.
`default_nettype none

module stepper_phase_sequencer
  import sps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic               in_half_step,
  input  wire logic               in_direction,
  input  wire logic [TICKS_W-1:0] in_phase_ticks,
  input  wire logic [ANGLE_W-1:0] in_angle_deg,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [3:0]         out_coils,
  output      logic               out_busy_res,
  output      logic               out_done_res,
  output      logic               out_start_ignored
);

  logic        item_valid;
  sps_item_t   item;
  sps_result_t result;
  logic        advance;
  logic        load;
  logic        out_valid_r;
  logic        out_valid_nxt;
  sps_result_t out_r;

  assign advance  = item_valid && (!out_valid_r || !out_stall);
  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  sps_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .advance     (advance),
    .kind        (in_kind),
    .half_step   (in_half_step),
    .direction   (in_direction),
    .phase_ticks (in_phase_ticks),
    .angle_deg   (in_angle_deg),
    .item_valid  (item_valid),
    .item        (item)
  );

  sps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coils         = out_r.coils;
  assign out_busy_res      = out_r.busy;
  assign out_done_res      = out_r.done;
  assign out_start_ignored = out_r.ignored;

endmodule

`default_nettype wire

// ===== rtl/sps_checker.sv =====
`default_nettype none

module sps_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_coils,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic       out_start_ignored
);

  // completion always leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // a dropped start only happens during a motion
  a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_ignored |-> out_busy_res && !out_done_res)
    else $error("start ignored while idle");

  // a running motion always energizes some coil
  a_busy_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_res |-> out_coils != 4'h0)
    else $error("busy with all coils off");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coils)
      && $stable(out_busy_res) && $stable(out_done_res))
    else $error("result changed under stall");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_coils         (out_coils),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_start_ignored (out_start_ignored)
);

`default_nettype wire
